[rtl/rtcto_pkg.sv]
// Shared types, constants and codes for the real-time clock timeout unit.
// No dependencies; every other file imports this package.
package rtcto_pkg;

    localparam logic [63:0] NS_PER_SEC  = 64'd1000000000;
    localparam logic [31:0] TICKS_MAX   = 32'hFFFF_FFFF;
    localparam logic [31:0] HZ_RESET    = 32'd100000000;
    localparam logic [19:0] TPS_RESET   = 20'd1000;

    // ceil(2^79 / 1e9): floor(x * NS_RECIP / 2^79) is x / 1e9 for any x below 2^50
    localparam logic [49:0] NS_RECIP    = 50'd604462909807315;

    // Command codes
    localparam logic [2:0] CMD_ADVANCE  = 3'd0;
    localparam logic [2:0] CMD_SET_RT   = 3'd1;
    localparam logic [2:0] CMD_GET_MONO = 3'd2;
    localparam logic [2:0] CMD_GET_RT   = 3'd3;
    localparam logic [2:0] CMD_DEADLINE = 3'd4;
    localparam logic [2:0] CMD_DURATION = 3'd5;

    // Work kinds after classification
    localparam logic [2:0] KIND_ADV  = 3'd0;
    localparam logic [2:0] KIND_SET  = 3'd1;
    localparam logic [2:0] KIND_MONO = 3'd2;
    localparam logic [2:0] KIND_REAL = 3'd3;
    localparam logic [2:0] KIND_DEAD = 3'd4;
    localparam logic [2:0] KIND_DUR  = 3'd5;
    localparam logic [2:0] KIND_BAD  = 3'd6;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_PASSED  = 2'd2;

    // Register indexes
    localparam logic REG_CLOCK_HZ = 1'b0;
    localparam logic REG_TPS      = 1'b1;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] elapsed_cycles;
        logic [31:0] in_sec;
        logic [29:0] in_nsec;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [44:0] out_sec;
        logic [29:0] out_nsec;
        logic [31:0] out_ticks;
    } result_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] elapsed;
        logic [31:0] sec;
        logic [29:0] nsec;
    } work_t;

endpackage

[rtl/rtcto_front.sv]
// Front end: accepts items, classifies and validates them, holds them in a
// two-entry queue for the back end. Depends on rtcto_pkg.
module rtcto_front
    import rtcto_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  item_t   item,
    output logic    full,
    output logic    work_valid,
    output work_t   work,
    input  logic    work_take
);

    work_t       q_mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    work_t       cls;
    logic        nsec_ok;
    logic        do_push;
    logic        do_pop;

    assign nsec_ok = {34'd0, item.in_nsec} < NS_PER_SEC;

    always_comb
    begin
        cls.elapsed = item.elapsed_cycles;
        cls.sec     = item.in_sec;
        cls.nsec    = item.in_nsec;
        unique case (item.cmd)
            CMD_ADVANCE:  cls.kind = KIND_ADV;
            CMD_SET_RT:   cls.kind = nsec_ok ? KIND_SET : KIND_BAD;
            CMD_GET_MONO: cls.kind = KIND_MONO;
            CMD_GET_RT:   cls.kind = KIND_REAL;
            CMD_DEADLINE: cls.kind = (nsec_ok && !item.in_sec[31]) ? KIND_DEAD : KIND_BAD;
            CMD_DURATION: cls.kind = nsec_ok ? KIND_DUR : KIND_BAD;
            default:      cls.kind = KIND_BAD;
        endcase
    end

    assign full       = count_reg[1];
    assign work_valid = (count_reg != 2'd0);
    assign work       = q_mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = work_take && work_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

[rtl/rtcto_div.sv]
// Shared 64-bit restoring divider, one quotient bit per cycle.
// Depends on rtcto_pkg for house consistency only through the import.
module rtcto_div
    import rtcto_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] quot,
    output logic [63:0] rem
);

    logic [63:0] q_reg;
    logic [63:0] r_reg;
    logic [63:0] d_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] trial;
    logic        fits;

    assign trial = {r_reg, q_reg[63]};
    assign fits  = trial >= {1'b0, d_reg};
    assign done  = done_reg;
    assign quot  = q_reg;
    assign rem   = r_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= 64'd0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            // shift in the next numerator bit, subtract where it fits
            if (fits)
            begin
                r_reg <= 64'(trial - {1'b0, d_reg});
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_reg <= trial[63:0];
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 7'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= 7'd64;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[rtl/rtcto_back.sv]
// Back end: sequencer that holds the counter and real-time offset and carries
// out each classified item with one shared multiplier and divider.
// Depends on rtcto_pkg and rtcto_div.
module rtcto_back
    import rtcto_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        work_valid,
    input  work_t       work,
    output logic        work_take,
    input  logic [31:0] hz_eff,
    input  logic [19:0] tps_eff,
    output logic        res_valid,
    output result_t     res,
    input  logic        res_ready
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_HW_DIV1 = 5'd1;
    localparam logic [4:0] S_HW_Q1   = 5'd2;
    localparam logic [4:0] S_HW_MUL  = 5'd3;
    localparam logic [4:0] S_HW_DIV2 = 5'd4;
    localparam logic [4:0] S_HW_Q2   = 5'd5;
    localparam logic [4:0] S_POST    = 5'd6;
    localparam logic [4:0] S_REAL    = 5'd7;
    localparam logic [4:0] S_DL_MUL1 = 5'd8;
    localparam logic [4:0] S_DL_MUL2 = 5'd9;
    localparam logic [4:0] S_DL_R0   = 5'd10;
    localparam logic [4:0] S_DL_R1   = 5'd11;
    localparam logic [4:0] S_DL_R2   = 5'd12;
    localparam logic [4:0] S_DL_R3   = 5'd13;
    localparam logic [4:0] S_DL_Q    = 5'd14;
    localparam logic [4:0] S_DU_DIV1 = 5'd15;
    localparam logic [4:0] S_DU_Q1   = 5'd16;
    localparam logic [4:0] S_DU_MUL  = 5'd17;
    localparam logic [4:0] S_DU_DIV2 = 5'd18;
    localparam logic [4:0] S_DU_Q2   = 5'd19;
    localparam logic [4:0] S_EMIT    = 5'd20;

    logic [4:0]  state_reg;
    work_t       w_reg;
    logic [63:0] cc_reg;
    logic [63:0] off_sec_reg;
    logic [29:0] off_nsec_reg;
    logic [63:0] hs_reg;
    logic [29:0] hn_reg;
    logic [63:0] cs_reg;
    logic [29:0] cn_reg;
    logic [63:0] prod_reg;
    logic [53:0] t_reg;
    logic [29:0] ptick_reg;
    logic [51:0] acc_reg;
    result_t     res_reg;

    logic        div_start;
    logic [63:0] div_num;
    logic [63:0] div_den;
    logic        div_done;
    logic [63:0] div_quot;
    logic [63:0] div_rem;

    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] mul_p;

    logic        borrow;
    logic [30:0] n_sum;
    logic        n_carry;
    logic [63:0] sec64;
    logic [63:0] diff;
    logic        passed;
    logic        up;
    logic [29:0] dn;
    logic [49:0] dl_x;
    logic [22:0] dl_q;
    logic [63:0] t_dl;
    logic [63:0] t_du;
    logic        du_sat;

    rtcto_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    assign sec64   = {32'd0, w_reg.sec};
    assign borrow  = w_reg.nsec < hn_reg;
    assign n_sum   = {1'b0, hn_reg} + {1'b0, off_nsec_reg};
    assign n_carry = {33'd0, n_sum} >= NS_PER_SEC;
    assign diff    = sec64 - cs_reg;
    assign passed  = ($signed(sec64) < $signed(cs_reg))
                  || ((sec64 == cs_reg) && (w_reg.nsec <= cn_reg));
    assign up      = w_reg.nsec > cn_reg;
    assign dn      = up ? (w_reg.nsec - cn_reg) : (cn_reg - w_reg.nsec);
    // numerator of the nanosecond tick fraction; minus one turns floor into ceiling
    assign dl_x    = up ? 50'(prod_reg - 64'd1) : prod_reg[49:0];
    assign dl_q    = acc_reg[51:29];
    assign t_dl    = up ? ({10'd0, t_reg} + {41'd0, dl_q} + 64'd1)
                        : ({10'd0, t_reg} - {41'd0, dl_q});
    assign t_du    = div_quot + {63'd0, (div_rem != 64'd0)};
    assign du_sat  = (div_quot[63:32] != 32'd0) || (t_du[63:32] != 32'd0);
    assign mul_p   = {32'd0, mul_a} * {33'd0, mul_b};

    always_comb
    begin
        unique case (state_reg)
            S_HW_MUL:  begin mul_a = {1'b0, div_rem[31:0]}; mul_b = NS_PER_SEC[31:0]; end
            S_DL_MUL1: begin mul_a = diff[32:0];            mul_b = {12'd0, tps_eff}; end
            S_DL_MUL2: begin mul_a = {3'd0, dn};            mul_b = {12'd0, tps_eff}; end
            S_DL_R0:
            begin
                mul_a = {8'd0, dl_x[24:0]};
                mul_b = {7'd0, NS_RECIP[24:0]};
            end
            S_DL_R1:
            begin
                mul_a = {8'd0, dl_x[49:25]};
                mul_b = {7'd0, NS_RECIP[24:0]};
            end
            S_DL_R2:
            begin
                mul_a = {8'd0, dl_x[24:0]};
                mul_b = {7'd0, NS_RECIP[49:25]};
            end
            S_DL_R3:
            begin
                mul_a = {8'd0, dl_x[49:25]};
                mul_b = {7'd0, NS_RECIP[49:25]};
            end
            S_DU_MUL:  begin mul_a = {1'b0, w_reg.sec};     mul_b = NS_PER_SEC[31:0]; end
            default:   begin mul_a = 33'd0;                 mul_b = 32'd0;            end
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = 64'd0;
        div_den   = 64'd1;
        unique case (state_reg)
            S_HW_DIV1:
            begin
                div_start = 1'b1;
                div_num   = cc_reg;
                div_den   = {32'd0, hz_eff};
            end
            S_HW_DIV2:
            begin
                div_start = 1'b1;
                div_num   = prod_reg;
                div_den   = {32'd0, hz_eff};
            end
            S_DU_DIV1:
            begin
                div_start = 1'b1;
                div_num   = NS_PER_SEC;
                div_den   = {44'd0, tps_eff};
            end
            S_DU_DIV2:
            begin
                div_start = 1'b1;
                div_num   = prod_reg + {34'd0, w_reg.nsec};
                div_den   = {34'd0, ptick_reg};
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign work_take = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT);
    assign res       = res_reg;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                w_reg   <= work;
                res_reg <= {((work.kind == KIND_BAD) ? ST_INVALID : ST_OK), 107'd0};
            end
            S_HW_Q1:
            begin
                if (div_done)
                begin
                    hs_reg <= div_quot;
                end
            end
            S_HW_MUL, S_DL_MUL2, S_DU_MUL:
            begin
                prod_reg <= mul_p[63:0];
            end
            S_HW_Q2:
            begin
                if (div_done)
                begin
                    hn_reg <= div_quot[29:0];
                end
            end
            S_POST:
            begin
                cs_reg <= hs_reg + off_sec_reg + {63'd0, n_carry};
                cn_reg <= n_carry ? 30'(n_sum - NS_PER_SEC[30:0]) : n_sum[29:0];
                if (w_reg.kind == KIND_MONO)
                begin
                    res_reg.out_sec  <= hs_reg[44:0];
                    res_reg.out_nsec <= hn_reg;
                end
            end
            S_REAL:
            begin
                if (w_reg.kind == KIND_REAL)
                begin
                    res_reg.out_sec  <= cs_reg[44:0];
                    res_reg.out_nsec <= cn_reg;
                end
                else if (passed)
                begin
                    res_reg.status <= ST_PASSED;
                end
                else if (diff[63:33] != 31'd0)
                begin
                    res_reg.out_ticks <= TICKS_MAX;
                end
            end
            S_DL_MUL1:
            begin
                t_reg <= mul_p[53:0];
            end
            // divide by 1e9 as a reciprocal product built from four 25-bit partials
            S_DL_R0:
            begin
                acc_reg <= {27'd0, mul_p[49:25]};
            end
            S_DL_R1, S_DL_R2:
            begin
                acc_reg <= acc_reg + {2'd0, mul_p[49:0]};
            end
            S_DL_R3:
            begin
                acc_reg <= {25'd0, acc_reg[51:25]} + {2'd0, mul_p[49:0]};
            end
            S_DL_Q:
            begin
                res_reg.out_ticks <= (t_dl[63:32] != 32'd0) ? TICKS_MAX : t_dl[31:0];
            end
            S_DU_Q1:
            begin
                if (div_done)
                begin
                    ptick_reg <= div_quot[29:0];
                end
            end
            S_DU_Q2:
            begin
                if (div_done)
                begin
                    res_reg.out_ticks <= du_sat ? TICKS_MAX : t_du[31:0];
                end
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cc_reg       <= 64'd0;
            off_sec_reg  <= 64'd0;
            off_nsec_reg <= 30'd0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (work_valid)
                    begin
                        unique case (work.kind)
                            KIND_ADV:
                            begin
                                cc_reg    <= cc_reg + {48'd0, work.elapsed};
                                state_reg <= S_EMIT;
                            end
                            KIND_BAD: state_reg <= S_EMIT;
                            KIND_DUR: state_reg <= S_DU_DIV1;
                            default:  state_reg <= S_HW_DIV1;
                        endcase
                    end
                end
                S_HW_DIV1: state_reg <= S_HW_Q1;
                S_HW_Q1:   if (div_done) state_reg <= S_HW_MUL;
                S_HW_MUL:  state_reg <= S_HW_DIV2;
                S_HW_DIV2: state_reg <= S_HW_Q2;
                S_HW_Q2:   if (div_done) state_reg <= S_POST;
                S_POST:
                begin
                    if (w_reg.kind == KIND_SET)
                    begin
                        // store requested time minus hardware time, borrow on ns
                        off_nsec_reg <= borrow
                            ? 30'(w_reg.nsec + NS_PER_SEC[29:0] - hn_reg)
                            : 30'(w_reg.nsec - hn_reg);
                        off_sec_reg  <= sec64 - hs_reg - {63'd0, borrow};
                        state_reg    <= S_EMIT;
                    end
                    else if (w_reg.kind == KIND_MONO)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_REAL;
                    end
                end
                S_REAL:
                begin
                    if (w_reg.kind == KIND_REAL || passed || diff[63:33] != 31'd0)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_DL_MUL1;
                    end
                end
                S_DL_MUL1: state_reg <= S_DL_MUL2;
                S_DL_MUL2: state_reg <= S_DL_R0;
                S_DL_R0:   state_reg <= S_DL_R1;
                S_DL_R1:   state_reg <= S_DL_R2;
                S_DL_R2:   state_reg <= S_DL_R3;
                S_DL_R3:   state_reg <= S_DL_Q;
                S_DL_Q:    state_reg <= S_EMIT;
                S_DU_DIV1: state_reg <= S_DU_Q1;
                S_DU_Q1:   if (div_done) state_reg <= S_DU_MUL;
                S_DU_MUL:  state_reg <= S_DU_DIV2;
                S_DU_DIV2: state_reg <= S_DU_Q2;
                S_DU_Q2:   if (div_done) state_reg <= S_EMIT;
                S_EMIT:    if (res_ready) state_reg <= S_IDLE;
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/realtime_clock_timeout_unit.sv]
// Top level of the real-time clock timeout unit: configuration registers,
// front end, back end and result queue. Depends on rtcto_pkg, rtcto_front,
// rtcto_back (which uses rtcto_div).
//
// The unit keeps a 64-bit cycle counter and a real-time offset and answers
// one result beat per command beat. Commands queue on push/full and results
// on pop/empty; each side holds two beats so either may stall on its own.
// Commands run one at a time. Advance and rejected commands go straight from
// idle to the result state. Every command that reads time or converts a
// duration runs the shared 64-step restoring divider twice; the deadline's
// divide by one billion is a reciprocal multiply, which a deadline that has
// passed or saturates skips. A full result queue stalls the back end. Write
// clock_hz (index 0) and ticks_per_second (index 1) only while the unit is
// idle; a value of zero in either acts as one.
module realtime_clock_timeout_unit
    import rtcto_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  item_t       item,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output result_t     result,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0] hz_reg;
    logic [19:0] tps_reg;
    logic [31:0] hz_eff;
    logic [19:0] tps_eff;

    logic        work_valid;
    work_t       work;
    logic        work_take;
    logic        res_valid;
    result_t     res;
    logic        res_ready;

    result_t     oq_mem [2];
    logic        oq_wr_reg;
    logic        oq_rd_reg;
    logic [1:0]  oq_cnt_reg;
    logic        oq_push;
    logic        oq_pop;

    // zero rates act as one
    assign hz_eff  = (hz_reg == 32'd0) ? 32'd1 : hz_reg;
    assign tps_eff = (tps_reg == 20'd0) ? 20'd1 : tps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hz_reg  <= HZ_RESET;
            tps_reg <= TPS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CLOCK_HZ: hz_reg  <= cfg_data;
                REG_TPS:      tps_reg <= cfg_data[19:0];
                default:      hz_reg  <= hz_reg;
            endcase
        end
    end

    rtcto_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (item),
        .full       (full),
        .work_valid (work_valid),
        .work       (work),
        .work_take  (work_take)
    );

    rtcto_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (work_valid),
        .work       (work),
        .work_take  (work_take),
        .hz_eff     (hz_eff),
        .tps_eff    (tps_eff),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready)
    );

    // Result queue: hold finished beats until popped
    assign res_ready = !oq_cnt_reg[1];
    assign oq_push   = res_valid && res_ready;
    assign empty     = (oq_cnt_reg == 2'd0);
    assign oq_pop    = pop && !empty;
    assign result    = oq_mem[oq_rd_reg];

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_mem[oq_wr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= 1'b0;
            oq_rd_reg  <= 1'b0;
            oq_cnt_reg <= 2'd0;
        end
        else
        begin
            if (oq_push)
            begin
                oq_wr_reg <= !oq_wr_reg;
            end
            if (oq_pop)
            begin
                oq_rd_reg <= !oq_rd_reg;
            end
            oq_cnt_reg <= oq_cnt_reg + {1'b0, oq_push} - {1'b0, oq_pop};
        end
    end

endmodule

[verif/tb_realtime_clock_timeout_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for realtime_clock_timeout_unit: directed and random
// command beats, a reference predictor and a result scoreboard. Depends on rtcto_pkg.
module tb_realtime_clock_timeout_unit;
    import rtcto_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [63:0] SAT_LIMIT = 64'h0000_0002_0000_0000;

    logic        clk;
    logic        rst_n;
    logic        push;
    item_t       item;
    logic        full;
    logic        empty;
    logic        pop;
    result_t     result;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    realtime_clock_timeout_unit dut (
        .clk(clk), .rst_n(rst_n), .push(push), .item(item), .full(full),
        .empty(empty), .pop(pop), .result(result), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Clock: 8 ns period.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor state: its own copy of the counter, offset and registers.
    logic [63:0] hz_reg;
    logic [63:0] tps_reg;
    logic [63:0] cycles_now;
    logic [63:0] rt_off_sec;
    logic [63:0] rt_off_nsec;

    result_t pending_results[$];
    int      fail_count;
    int      cycle_count;
    int      send_idle_pct;
    int      take_idle_pct;
    int      hold_off_cycles;

    // Monotonic time from the cycle counter.
    function automatic void mono_time(output logic [63:0] sec, output logic [63:0] nsec);
        logic [63:0] hz;
        hz   = (hz_reg == 0) ? 64'd1 : hz_reg;
        sec  = cycles_now / hz;
        nsec = ((cycles_now % hz) * NS_PER_SEC) / hz;
    endfunction

    // Real time: monotonic plus offset, with the nanosecond carry.
    function automatic void real_time_now(output logic [63:0] sec, output logic [63:0] nsec);
        logic [63:0] hs;
        logic [63:0] hn;
        logic [63:0] n;
        mono_time(hs, hn);
        n    = hn + rt_off_nsec;
        sec  = hs + rt_off_sec + ((n >= NS_PER_SEC) ? 64'd1 : 64'd0);
        nsec = n % NS_PER_SEC;
    endfunction

    // Apply one command beat to the predictor; return the expected result.
    function automatic result_t clock_cmd_result(item_t it);
        result_t     r;
        logic [63:0] sec;
        logic [63:0] nsec;
        logic [63:0] hs;
        logic [63:0] hn;
        logic [63:0] diff;
        logic [63:0] tps;
        logic [63:0] t;
        logic [63:0] per_tick;
        logic [63:0] ns;
        logic        nsec_ok;
        logic        passed;
        r       = '0;
        sec     = {32'd0, it.in_sec};
        nsec    = {34'd0, it.in_nsec};
        nsec_ok = nsec < NS_PER_SEC;
        tps     = (tps_reg == 0) ? 64'd1 : tps_reg;
        case (it.cmd)
            CMD_ADVANCE: cycles_now = cycles_now + {48'd0, it.elapsed_cycles};
            CMD_SET_RT:
            begin
                if (!nsec_ok)
                    r.status = ST_INVALID;
                else
                begin
                    mono_time(hs, hn);
                    if (nsec < hn)
                    begin
                        rt_off_nsec = nsec + NS_PER_SEC - hn;
                        rt_off_sec  = sec - hs - 64'd1;
                    end
                    else
                    begin
                        rt_off_nsec = nsec - hn;
                        rt_off_sec  = sec - hs;
                    end
                end
            end
            CMD_GET_MONO:
            begin
                mono_time(hs, hn);
                r.out_sec  = hs[44:0];
                r.out_nsec = hn[29:0];
            end
            CMD_GET_RT:
            begin
                real_time_now(hs, hn);
                r.out_sec  = hs[44:0];
                r.out_nsec = hn[29:0];
            end
            CMD_DEADLINE:
            begin
                if (!nsec_ok || sec > 64'h7FFF_FFFF)
                    r.status = ST_INVALID;
                else
                begin
                    real_time_now(hs, hn);
                    // current seconds compare as a signed value
                    passed = ($signed(sec) < $signed(hs))
                          || (sec == hs && nsec <= hn);
                    if (passed)
                        r.status = ST_PASSED;
                    else
                    begin
                        diff = sec - hs;
                        if (diff >= SAT_LIMIT)
                            t = {32'd0, TICKS_MAX};
                        else
                        begin
                            t = diff * tps;
                            // round up when nanoseconds lie ahead, down otherwise
                            if (nsec > hn)
                                t = t + ((nsec - hn) * tps - 64'd1) / NS_PER_SEC + 64'd1;
                            else
                                t = t - ((hn - nsec) * tps) / NS_PER_SEC;
                        end
                        r.out_ticks = (t >= {32'd0, TICKS_MAX}) ? TICKS_MAX : t[31:0];
                    end
                end
            end
            CMD_DURATION:
            begin
                if (!nsec_ok)
                    r.status = ST_INVALID;
                else
                begin
                    per_tick = NS_PER_SEC / tps;
                    ns       = sec * NS_PER_SEC + nsec;
                    t        = ns / per_tick;
                    if (ns - t * per_tick > 0)
                        t = t + 64'd1;
                    r.out_ticks = (t > {32'd0, TICKS_MAX}) ? TICKS_MAX : t[31:0];
                end
            end
            default: r.status = ST_INVALID;
        endcase
        return r;
    endfunction

    // Offer one beat; hold it until accepted, then record the expectation.
    // Push stays high afterwards so back-to-back beats need no extra edge.
    task automatic send_cmd(logic [2:0] cmd, logic [15:0] elapsed,
                            logic [31:0] sec, logic [29:0] nsec);
        item_t it;
        it.cmd            = cmd;
        it.elapsed_cycles = elapsed;
        it.in_sec         = sec;
        it.in_nsec        = nsec;
        @(negedge clk);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            push = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        item = it;
        push = 1'b1;
        do
            @(posedge clk);
        while (full);
        pending_results.push_back(clock_cmd_result(it));
    endtask

    // Drop push and wait for every outstanding result to drain.
    task automatic drain_results();
        @(negedge clk);
        push = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write one register while the unit is idle.
    task automatic write_reg(logic idx, logic [31:0] value);
        drain_results();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_CLOCK_HZ)
            hz_reg = {32'd0, value};
        else
            tps_reg = {44'd0, value[19:0]};
    endtask

    // Receiver: random pop, or a counted hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            pop = 1'b0;
            hold_off_cycles = hold_off_cycles - 1;
        end
        else
            pop = ($urandom_range(0, 99) >= take_idle_pct);
    end

    // Scoreboard: compare every accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat: %p", result);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, result.status);
                    fail_count++;
                end
                if (result.out_sec !== want.out_sec)
                begin
                    $error("out_sec: expected %0d, actual %0d", want.out_sec, result.out_sec);
                    fail_count++;
                end
                if (result.out_nsec !== want.out_nsec)
                begin
                    $error("out_nsec: expected %0d, actual %0d",
                           want.out_nsec, result.out_nsec);
                    fail_count++;
                end
                if (result.out_ticks !== want.out_ticks)
                begin
                    $error("out_ticks: expected %0d, actual %0d",
                           want.out_ticks, result.out_ticks);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: abort a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Reads straight after reset, unused commands and bad nanoseconds.
    task automatic test_reset_and_rejects();
        send_cmd(CMD_GET_MONO, 16'h0000, 32'd0, 30'd0);
        send_cmd(CMD_GET_RT, 16'h0000, 32'd0, 30'd0);
        send_cmd(3'd6, 16'hFFFF, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
        send_cmd(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
        send_cmd(CMD_SET_RT, 16'h0000, 32'd5, 30'd1000000000);
        send_cmd(CMD_DEADLINE, 16'h0000, 32'd5, 30'h3FFF_FFFF);
        send_cmd(CMD_DURATION, 16'h0000, 32'd5, 30'd1000000000);
        send_cmd(CMD_GET_RT, 16'h0000, 32'd0, 30'd0);
    endtask

    // Advance the counter, set real time with and without borrow, read both clocks.
    task automatic test_set_and_read();
        send_cmd(CMD_ADVANCE, 16'hFFFF, 32'd0, 30'd0);
        send_cmd(CMD_ADVANCE, 16'h1234, 32'd0, 30'd0);
        send_cmd(CMD_GET_MONO, 16'h0000, 32'd0, 30'd0);
        send_cmd(CMD_SET_RT, 16'h0000, 32'd100, 30'd0);
        send_cmd(CMD_GET_RT, 16'h0000, 32'd0, 30'd0);
        send_cmd(CMD_SET_RT, 16'h0000, 32'hFFFF_FFFF, 30'd999999999);
        send_cmd(CMD_GET_RT, 16'h0000, 32'd0, 30'd0);
        // requested time below hardware time: negative offset
        send_cmd(CMD_SET_RT, 16'h0000, 32'd0, 30'd0);
        send_cmd(CMD_GET_RT, 16'h0000, 32'd0, 30'd0);
    endtask

    // Deadlines: too large, passed, exactly now, just ahead, far ahead.
    task automatic test_deadlines();
        logic [63:0] cs;
        logic [63:0] cn;
        send_cmd(CMD_DEADLINE, 16'h0000, 32'h8000_0000, 30'd0);
        send_cmd(CMD_DEADLINE, 16'h0000, 32'd0, 30'd0);
        send_cmd(CMD_SET_RT, 16'h0000, 32'd1000, 30'd500000000);
        real_time_now(cs, cn);
        send_cmd(CMD_DEADLINE, 16'h0000, cs[31:0], cn[29:0]);
        send_cmd(CMD_DEADLINE, 16'h0000, cs[31:0], cn[29:0] + 30'd1);
        send_cmd(CMD_DEADLINE, 16'h0000, cs[31:0] + 32'd3, 30'd0);
        send_cmd(CMD_DEADLINE, 16'h0000, 32'h7FFF_FFFF, 30'd999999999);
    endtask

    // Durations at the extremes, including saturation.
    task automatic test_durations();
        send_cmd(CMD_DURATION, 16'h0000, 32'd0, 30'd0);
        send_cmd(CMD_DURATION, 16'h0000, 32'd0, 30'd1);
        send_cmd(CMD_DURATION, 16'h0000, 32'hFFFF_FFFF, 30'd999999999);
    endtask

    // Register extremes, zero rates acting as one.
    task automatic test_register_extremes();
        logic [31:0] hz_set[4]  = '{32'd0, 32'd1000000, 32'd4000000000, 32'd100000000};
        logic [31:0] tps_set[4] = '{32'd0, 32'd1, 32'd1000000, 32'd1000};
        for (int k = 0; k < 4; k++)
        begin
            write_reg(REG_CLOCK_HZ, hz_set[k]);
            write_reg(REG_TPS, tps_set[k]);
            send_cmd(CMD_ADVANCE, 16'hFFFF, 32'd0, 30'd0);
            send_cmd(CMD_GET_MONO, 16'h0000, 32'd0, 30'd0);
            send_cmd(CMD_GET_RT, 16'h0000, 32'd0, 30'd0);
            send_cmd(CMD_DEADLINE, 16'h0000, 32'h7FFF_FFFF, 30'd0);
            send_cmd(CMD_DURATION, 16'h0000, 32'd1, 30'd1);
        end
    endtask

    // Receiver holds off while beats keep coming, so the unit fills and stalls.
    task automatic test_backpressure();
        hold_off_cycles = 1500;
        for (int k = 0; k < 10; k++)
            send_cmd(CMD_GET_RT, 16'h0000, 32'd0, 30'd0);
        drain_results();
    endtask

    // Pick one random command, mostly well-formed and near the current time.
    task automatic send_random_cmd();
        logic [63:0] cs;
        logic [63:0] cn;
        logic [31:0] sec;
        logic [29:0] nsec;
        int          pick;
        pick = $urandom_range(0, 99);
        nsec = ($urandom_range(0, 19) == 0) ? 30'($urandom) : 30'($urandom_range(0, 999999999));
        if (pick < 28)
            send_cmd(CMD_ADVANCE, 16'($urandom), 32'($urandom), 30'($urandom));
        else if (pick < 36)
        begin
            sec = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100000);
            send_cmd(CMD_SET_RT, 16'($urandom), sec, nsec);
        end
        else if (pick < 48)
            send_cmd(CMD_GET_MONO, 16'($urandom), 32'($urandom), 30'($urandom));
        else if (pick < 60)
            send_cmd(CMD_GET_RT, 16'($urandom), 32'($urandom), 30'($urandom));
        else if (pick < 82)
        begin
            real_time_now(cs, cn);
            if ($urandom_range(0, 3) != 0 && $signed(cs) >= 0 && cs < 64'h7FFF_0000)
            begin
                // deadline around now: just passed to a few seconds ahead
                sec = cs[31:0] + 32'($urandom_range(0, 6)) - 32'($urandom_range(0, 1));
                if ($urandom_range(0, 2) == 0)
                    nsec = cn[29:0] + 30'($urandom_range(0, 2)) - 30'($urandom_range(0, 1));
            end
            else
                sec = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 32'h7FFF_FFFF);
            send_cmd(CMD_DEADLINE, 16'($urandom), sec, nsec);
        end
        else if (pick < 96)
        begin
            sec = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20);
            send_cmd(CMD_DURATION, 16'($urandom), sec, nsec);
        end
        else
            send_cmd(3'($urandom_range(6, 7)), 16'($urandom), $urandom, 30'($urandom));
    endtask

    // Random phases under several register settings and idling patterns.
    task automatic test_random_traffic();
        logic [31:0] hz_set[6]  = '{32'd1000000, 32'd4000000000, 32'd33333333,
                                    32'd1000003, 32'd2500000000, 32'd100000000};
        logic [31:0] tps_set[6] = '{32'd1000000, 32'd1, 32'd7, 32'd999983,
                                    32'd100, 32'd1000};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_CLOCK_HZ, hz_set[ph]);
            write_reg(REG_TPS, tps_set[ph]);
            if (ph < 2)
            begin
                send_idle_pct = 24;
                take_idle_pct = 74;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 74;
                take_idle_pct = 24;
            end
            else
            begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            for (int k = 0; k < 315; k++)
                send_random_cmd();
        end
        drain_results();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        push            = 1'b0;
        item            = '0;
        pop             = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_CLOCK_HZ;
        cfg_data        = '0;
        fail_count      = 0;
        cycle_count     = 0;
        hold_off_cycles = 0;
        send_idle_pct   = 24;
        take_idle_pct   = 74;
        hz_reg          = {32'd0, HZ_RESET};
        tps_reg         = {44'd0, TPS_RESET};
        cycles_now      = '0;
        rt_off_sec      = '0;
        rt_off_nsec     = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_and_rejects();
        test_set_and_read();
        test_deadlines();
        test_durations();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();

        drain_results();
        repeat (250) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
